// File: rtl/core/b32enc_pkg.sv
// Shared constants, codes and checksum helpers for the bech32 string encoder.
package b32enc_pkg;

  // Readable-part store sizing
  localparam int MAX_PREFIX = 64;
  localparam int PFX_AW     = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
  localparam int CNT_W      = $clog2(MAX_PREFIX + 1);
  localparam int CHAR_W     = 7;
  localparam int SYM_W      = 5;
  localparam int ACC_W      = 30;
  localparam int SYM_CNT_W  = 7;

  // Encoded string limit (part + separator + data + checksum)
  localparam int TOTAL_LIMIT = 108;
  localparam int CKS_LEN     = 6;

  // Printable range for readable-part characters
  localparam logic [7:0] CHAR_MIN = 8'd33;
  localparam logic [7:0] CHAR_MAX = 8'd126;
  localparam logic [CHAR_W-1:0] SEP_CHAR = 7'h31;  // '1'

  // Polymod generator
  localparam logic [ACC_W-1:0] GEN0 = 30'h3b6a57b2;
  localparam logic [ACC_W-1:0] GEN1 = 30'h26508e6d;
  localparam logic [ACC_W-1:0] GEN2 = 30'h1ea119fa;
  localparam logic [ACC_W-1:0] GEN3 = 30'h3d4233dd;
  localparam logic [ACC_W-1:0] GEN4 = 30'h2a1462b3;

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // Input commands
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_SYM  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_CHAR = 3'd1;
  localparam logic [2:0] STAT_SYM_BIG  = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NO_DATA  = 3'd4;
  localparam logic [2:0] STAT_TOO_LONG = 3'd5;

  // One polymod step: shift in five zero bits, fold the top five back in
  function automatic logic [ACC_W-1:0] pm_step(input logic [ACC_W-1:0] pre);
    logic [4:0]       top;
    logic [ACC_W-1:0] r;
    top = pre[29:25];
    r   = {pre[24:0], 5'b0};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  // 5-bit symbol to charset character
  function automatic logic [CHAR_W-1:0] charset_char(input logic [SYM_W-1:0] sym);
    logic [7:0] c;
    c = CHARSET[(31 - int'(sym)) * 8 +: 8];
    return c[CHAR_W-1:0];
  endfunction

endpackage

// File: rtl/core/b32enc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module b32enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/bech32_string_encoder_top.sv
// Bech32 string encoder: readable part, separator, data and checksum characters.
//
//  channel | handshake           | payload                    | width
//  --------+---------------------+----------------------------+--------
//  input   | in_valid / in_stall | command, value             | 2, 8
//  output  | out_valid/out_stall | character, last, status    | 7, 1, 3
//
// Steps: a readable-part character, a later data symbol or an error is taken
// and answered straight from the idle state. The first data symbol walks the N
// stored part characters, reading the prefix store through its single read port,
// then emits the separator and the symbol character. The end command runs 6
// checksum steps, then emits the 6 checksum characters.
// Reset: control state, the checksum and the counts clear; the
// prefix store needs no clearing, only entries of the current message are read.
// Stalls: one input skid register lets a transfer land while a result waits in
// the output register; out_stall freezes it and the emitting sequencer states.
module bech32_string_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] character,
  output logic       last,
  output logic [2:0] status
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take the next held item
  localparam logic [2:0] S_WALK = 3'd1;  // fold stored part low bits
  localparam logic [2:0] S_SYM1 = 3'd2;  // emit separator, fold first symbol
  localparam logic [2:0] S_SYM2 = 3'd3;  // emit first symbol character
  localparam logic [2:0] S_CKS  = 3'd4;  // six zero steps for the checksum
  localparam logic [2:0] S_OUT  = 3'd5;  // emit six checksum characters

  // Message phase
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  localparam int AW  = b32enc_pkg::PFX_AW;
  localparam int CW  = b32enc_pkg::CNT_W;
  localparam int SCW = b32enc_pkg::SYM_CNT_W;
  localparam int XW  = 8;  // width of the length sum

  // Control and state registers
  logic [2:0]                     state, state_next;
  logic [1:0]                     phase, phase_next;
  logic [b32enc_pkg::ACC_W-1:0]   acc, acc_next;
  logic [CW-1:0]                  prefix_count, prefix_count_next;
  logic [SCW-1:0]                 symbol_count, symbol_count_next;
  logic [AW-1:0]                  walk_idx, walk_idx_next;
  logic [2:0]                     step, step_next;
  logic [b32enc_pkg::SYM_W-1:0]   sym_hold, sym_hold_next;

  // Input skid
  logic       hold_valid;
  logic [1:0] cmd_q;
  logic [7:0] val_q;
  logic       in_xfer;
  logic       consume;

  // Output register
  logic       slot_free;
  logic       emit;
  logic [6:0] emit_char;
  logic       emit_last;
  logic [2:0] emit_status;

  // Prefix store port
  logic                          wr_en;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [b32enc_pkg::CHAR_W-1:0] rd_data;
  logic                          walk_last;
  logic [XW-1:0]                 total_len;

  assign slot_free = !out_valid || !out_stall;
  assign consume   = hold_valid && (state == S_IDLE) && slot_free;
  assign in_stall  = hold_valid && !consume;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_xfer) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q <= command;
      val_q <= value;
    end
  end

  assign walk_last = (CW'(walk_idx) + CW'(1)) == prefix_count;
  assign rd_en     = (state == S_IDLE) || ((state == S_WALK) && !walk_last);
  assign rd_addr   = (state == S_WALK) ? walk_idx + AW'(1) : '0;

  // Length after this symbol, plus separator and checksum
  assign total_len = XW'(prefix_count) + XW'(symbol_count) + XW'(2 + b32enc_pkg::CKS_LEN);

  b32enc_ram #(
    .WIDTH (b32enc_pkg::CHAR_W),
    .DEPTH (b32enc_pkg::MAX_PREFIX),
    .AW    (AW)
  ) u_prefix_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (prefix_count[AW-1:0]),
    .wr_data (val_q[6:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    acc_next          = acc;
    prefix_count_next = prefix_count;
    symbol_count_next = symbol_count;
    walk_idx_next     = walk_idx;
    step_next         = step;
    sym_hold_next     = sym_hold;
    wr_en             = 1'b0;
    emit              = 1'b0;
    emit_char         = '0;
    emit_last         = 1'b0;
    emit_status       = b32enc_pkg::STAT_OK;

    case (state)
      S_IDLE: begin
        if (consume) begin
          if (phase != PH_PREFIX && phase != PH_DATA) begin
            // dropping until the end command
            if (cmd_q == b32enc_pkg::CMD_END) begin
              phase_next        = PH_PREFIX;
              acc_next          = b32enc_pkg::ACC_W'(1);
              prefix_count_next = '0;
              symbol_count_next = '0;
            end
          end else begin
            case (cmd_q)
              b32enc_pkg::CMD_CHAR: begin
                if (phase == PH_PREFIX) begin
                  if (val_q < b32enc_pkg::CHAR_MIN || val_q > b32enc_pkg::CHAR_MAX) begin
                    emit        = 1'b1;
                    emit_last   = 1'b1;
                    emit_status = b32enc_pkg::STAT_BAD_CHAR;
                    phase_next  = PH_ERROR;
                  end else if (prefix_count >= CW'(b32enc_pkg::MAX_PREFIX)) begin
                    emit        = 1'b1;
                    emit_last   = 1'b1;
                    emit_status = b32enc_pkg::STAT_TOO_LONG;
                    phase_next  = PH_ERROR;
                  end else begin
                    acc_next = b32enc_pkg::pm_step(acc)
                               ^ b32enc_pkg::ACC_W'(val_q[7:5]);
                    wr_en             = 1'b1;
                    prefix_count_next = prefix_count + CW'(1);
                    emit              = 1'b1;
                    emit_char         = val_q[6:0];
                  end
                end
              end
              b32enc_pkg::CMD_SYM: begin
                if (prefix_count == '0) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = b32enc_pkg::STAT_EMPTY;
                  phase_next  = PH_ERROR;
                end else if (val_q[7:5] != 3'd0) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = b32enc_pkg::STAT_SYM_BIG;
                  phase_next  = PH_ERROR;
                end else if (total_len > XW'(b32enc_pkg::TOTAL_LIMIT)) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = b32enc_pkg::STAT_TOO_LONG;
                  phase_next  = PH_ERROR;
                end else if (phase == PH_PREFIX) begin
                  // separator step now, entry 0 read is in flight
                  acc_next      = b32enc_pkg::pm_step(acc);
                  walk_idx_next = '0;
                  sym_hold_next = val_q[4:0];
                  state_next    = S_WALK;
                end else begin
                  acc_next = b32enc_pkg::pm_step(acc)
                             ^ b32enc_pkg::ACC_W'(val_q[4:0]);
                  symbol_count_next = symbol_count + SCW'(1);
                  emit              = 1'b1;
                  emit_char         = b32enc_pkg::charset_char(val_q[4:0]);
                end
              end
              b32enc_pkg::CMD_END: begin
                if (prefix_count == '0 || phase != PH_DATA) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = (prefix_count == '0) ? b32enc_pkg::STAT_EMPTY
                                                     : b32enc_pkg::STAT_NO_DATA;
                  phase_next        = PH_PREFIX;
                  acc_next          = b32enc_pkg::ACC_W'(1);
                  prefix_count_next = '0;
                  symbol_count_next = '0;
                end else begin
                  step_next  = '0;
                  state_next = S_CKS;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_WALK: begin
        acc_next = b32enc_pkg::pm_step(acc)
                   ^ b32enc_pkg::ACC_W'(rd_data[b32enc_pkg::SYM_W-1:0]);
        if (walk_last) begin
          state_next = S_SYM1;
        end else begin
          walk_idx_next = walk_idx + AW'(1);
        end
      end
      S_SYM1: begin
        if (slot_free) begin
          acc_next          = b32enc_pkg::pm_step(acc) ^ b32enc_pkg::ACC_W'(sym_hold);
          symbol_count_next = SCW'(1);
          phase_next        = PH_DATA;
          emit              = 1'b1;
          emit_char         = b32enc_pkg::SEP_CHAR;
          state_next        = S_SYM2;
        end
      end
      S_SYM2: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = b32enc_pkg::charset_char(sym_hold);
          state_next = S_IDLE;
        end
      end
      S_CKS: begin
        if (step == 3'(b32enc_pkg::CKS_LEN - 1)) begin
          acc_next   = b32enc_pkg::pm_step(acc) ^ b32enc_pkg::ACC_W'(1);
          step_next  = '0;
          state_next = S_OUT;
        end else begin
          acc_next  = b32enc_pkg::pm_step(acc);
          step_next = step + 3'd1;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = b32enc_pkg::charset_char(acc[29:25]);
          acc_next  = {acc[24:0], 5'b0};
          if (step == 3'(b32enc_pkg::CKS_LEN - 1)) begin
            emit_last         = 1'b1;
            phase_next        = PH_PREFIX;
            acc_next          = b32enc_pkg::ACC_W'(1);
            prefix_count_next = '0;
            symbol_count_next = '0;
            state_next        = S_IDLE;
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_PREFIX;
      acc          <= b32enc_pkg::ACC_W'(1);
      prefix_count <= '0;
      symbol_count <= '0;
      step         <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      acc          <= acc_next;
      prefix_count <= prefix_count_next;
      symbol_count <= symbol_count_next;
      step         <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_idx <= walk_idx_next;
    sym_hold <= sym_hold_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      character <= emit_char;
      last      <= emit_last;
      status    <= emit_status;
    end
  end

endmodule

// File: rtl/core/b32enc_checker.sv
// Port-level checks for the bech32 string encoder, bound to the top level.
module b32enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] command,
  input logic [7:0] value,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] character,
  input logic       last,
  input logic [2:0] status
);

  // A stalled result transfer holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(character) && $stable(last)
                               && $stable(status))
    else $error("stalled result changed");

  // Error results end the message and carry no character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != b32enc_pkg::STAT_OK |-> last && character == 7'd0)
    else $error("error result malformed");

  // Only defined status codes appear
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == b32enc_pkg::STAT_OK || status == b32enc_pkg::STAT_BAD_CHAR
                  || status == b32enc_pkg::STAT_SYM_BIG || status == b32enc_pkg::STAT_EMPTY
                  || status == b32enc_pkg::STAT_NO_DATA || status == b32enc_pkg::STAT_TOO_LONG)
    else $error("undefined status code");

  // Reset empties the output register and the input skid
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left a transfer pending");

endmodule

bind bech32_string_encoder_top b32enc_checker u_b32enc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .command   (command),
  .value     (value),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .character (character),
  .last      (last),
  .status    (status)
);
